FILE: hw/rtl/double_ended_queue_core_assert.svh
// Assertion macros for the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define DQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle, outside reset.
`define DQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dq_pkg.sv
// Shared types, constants and ring-index helpers for the double-ended queue.
package dq_pkg;

  // Ring geometry.
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Request codes on the input channel.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_LIST
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } back_stat_t;

  // Next ring position, wrapping at the last entry.
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] r;
    r = (pos == LAST_IDX) ? '0 : pos + 1'b1;
    return r;
  endfunction

  // Previous ring position, wrapping at zero.
  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] r;
    r = (pos == '0) ? LAST_IDX : pos - 1'b1;
    return r;
  endfunction

  // Ring position plus an offset of at most DEPTH: one compare and subtract.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] pos,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(pos) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/dq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/dq_front.sv
// Front end: accepts request beats, classifies them and queues commands.
module dq_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] item_value,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output dq_pkg::cmd_t                 cmd
);
  import dq_pkg::*;

  // Two-entry command queue.
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  cmd_t       cls_cmd;
  logic       cls_ok;
  logic       push;
  logic       pop;

  // Decode the request code; unused codes are accepted and dropped.
  always_comb begin
    cls_ok       = 1'b1;
    cls_cmd.value = item_value;
    case (req_type)
      REQ_PUSH_FRONT: cls_cmd.op = OP_PUSH_FRONT;
      REQ_PUSH_REAR:  cls_cmd.op = OP_PUSH_REAR;
      REQ_POP_FRONT:  cls_cmd.op = OP_POP_FRONT;
      REQ_POP_REAR:   cls_cmd.op = OP_POP_REAR;
      REQ_LIST:       cls_cmd.op = OP_LIST;
      default: begin
        cls_cmd.op = OP_LIST;
        cls_ok     = 1'b0;
      end
    endcase
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready && cls_ok;
  assign pop       = cmd_valid && cmd_ready;

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls_cmd;
    end
  end

endmodule

FILE: hw/rtl/dq_back.sv
// Back end: executes queued commands on the entry ring and drives results.
module dq_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  dq_pkg::cmd_t                     cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dq_pkg::DATA_W-1:0] value,
  output logic [1:0]                       status,
  output logic                             last,
  output dq_pkg::back_stat_t               stat
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remain;
  logic [IDX_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_ptr_next;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] rd_data;

  logic out_free;
  logic take;
  logic full;
  logic empty;
  logic beat_load;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign stat.count = count;
  assign stat.busy  = (state != S_IDLE);

  // A new result beat is loaded for pushes, empty reports and each read beat.
  always_comb begin
    beat_load = 1'b0;
    if (take) begin
      case (cmd.op)
        OP_PUSH_FRONT, OP_PUSH_REAR: beat_load = 1'b1;
        default:                     beat_load = empty;
      endcase
    end else if (state == S_READ && out_free) begin
      beat_load = 1'b1;
    end
  end

  // Write and read addresses into the ring.
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = ring_prev(front);
    rd_ptr_next = rd_ptr;
    if (take) begin
      case (cmd.op)
        OP_PUSH_FRONT: begin
          wr_en   = !full;
          wr_addr = ring_prev(front);
        end
        OP_PUSH_REAR: begin
          wr_en   = !full;
          wr_addr = ring_add(front, count);
        end
        OP_POP_FRONT: rd_ptr_next = front;
        OP_POP_REAR:  rd_ptr_next = ring_add(front, count - 1'b1);
        OP_LIST:      rd_ptr_next = front;
        default:      rd_ptr_next = rd_ptr;
      endcase
    end else if (state == S_READ && out_free && remain != CNT_W'(1)) begin
      rd_ptr_next = ring_next(rd_ptr);
    end
  end

  dq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(cmd.value),
    .rd_addr(rd_ptr_next),
    .rd_data(rd_data)
  );

  // Read pointer follows the address presented to the RAM.
  always_ff @(posedge clk) begin
    rd_ptr <= rd_ptr_next;
  end

  // Sequencer, ring pointers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (cmd.op)
              OP_PUSH_FRONT, OP_PUSH_REAR: begin
                value     <= '0;
                last      <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= count + 1'b1;
                  if (cmd.op == OP_PUSH_FRONT) begin
                    front <= ring_prev(front);
                  end
                end
              end
              OP_POP_FRONT, OP_POP_REAR, OP_LIST: begin
                if (empty) begin
                  value     <= '0;
                  status    <= ST_EMPTY;
                  last      <= 1'b1;
                end else begin
                  state <= S_READ;
                  if (cmd.op == OP_LIST) begin
                    remain <= count;
                  end else begin
                    remain <= CNT_W'(1);
                    count  <= count - 1'b1;
                    if (cmd.op == OP_POP_FRONT) begin
                      front <= ring_next(front);
                    end
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            value     <= rd_data;
            status    <= ST_OK;
            last      <= (remain == CNT_W'(1));
            remain    <= remain - 1'b1;
            if (remain == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Input channel: in_valid/in_ready with req_type and item_value. Codes are
// push front, push rear, pop front, pop rear and list all; codes five to
// seven are accepted and produce nothing. Output channel: out_valid/out_ready
// with value, status and last; every other request ends with a beat marked last.
// A two-entry command queue sits between the front end and the back end.
// Push and status-only results pass through the command queue and the result
// register, and the back end takes one such request per cycle while the result
// register is free. A pop waits in the read state for the registered RAM read,
// so the back end takes no new request until its beat is loaded. A listing
// emits one beat per cycle while the result register is free. Reset empties
// the queue and clears all valid flags; the entry RAM is not cleared. When the
// receiver stalls, the result register holds its beat, the back end stops, and
// once the command queue fills in_ready drops.
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       req_type,
  input  logic signed [dq_pkg::DATA_W-1:0] item_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dq_pkg::DATA_W-1:0] value,
  output logic [1:0]                       status,
  output logic                             last
);
  import dq_pkg::*;

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  back_stat_t stat;

  // Request intake and classification.
  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .item_value(item_value),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Ring execution and result register.
  dq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value    (value),
    .status   (status),
    .last     (last),
    .stat     (stat)
  );

  // Consistency checks on the ring occupancy and on error result beats.
  `DQ_ASSERT_ALWAYS(a_count_bound, stat.count <= CNT_W'(DEPTH), "entry count exceeds depth")
  `DQ_ASSERT_IMPLY(a_err_beat, out_valid && status != ST_OK, value == '0 && last, "bad error beat")
  `DQ_ASSERT_IMPLY(a_full_beat, out_valid && status == ST_FULL, stat.count == CNT_W'(DEPTH), "full flagged while not full")
  `DQ_ASSERT_IMPLY(a_empty_beat, out_valid && status == ST_EMPTY, stat.count == '0, "empty flagged while not empty")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the double-ended queue core with a ring-buffer predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  // Request codes the block accepts and then ignores.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS  = 420;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 2000;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIX} phase_t;

  // One beat on the result channel.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
    logic                     last;
  } deque_beat_t;

  // Predicts the result beats of each request and checks the beats that leave the block.
  class deque_scoreboard_t;
    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]         head;
    logic [CNT_W-1:0]         fill;
    deque_beat_t              awaited [$];
    int                       mismatches;

    function new();
      head = '0;
      fill = '0;
      mismatches = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function logic [IDX_W-1:0] wrap(int pos);
      return IDX_W'(pos % DEPTH);
    endfunction

    function void queue_beat(logic signed [DATA_W-1:0] v, logic [1:0] st, logic lst);
      deque_beat_t b;
      b.value = v;
      b.status = st;
      b.last = lst;
      awaited.push_back(b);
    endfunction

    function int stored();
      return int'(fill);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Update the queue image for one accepted request and queue its beats.
    function void note_request(logic [2:0] kind, logic signed [DATA_W-1:0] data);
      int k;
      case (kind)
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          if (fill == CNT_W'(DEPTH)) begin
            queue_beat('0, ST_FULL, 1'b1);
          end else begin
            if (kind == REQ_PUSH_FRONT) begin
              head = wrap(int'(head) + DEPTH - 1);
              ring[head] = data;
            end else begin
              ring[wrap(int'(head) + int'(fill))] = data;
            end
            fill++;
            queue_beat('0, ST_OK, 1'b1);
          end
        end
        REQ_POP_FRONT: begin
          if (fill == '0) begin
            queue_beat('0, ST_EMPTY, 1'b1);
          end else begin
            queue_beat(ring[head], ST_OK, 1'b1);
            head = wrap(int'(head) + 1);
            fill--;
          end
        end
        REQ_POP_REAR: begin
          if (fill == '0) begin
            queue_beat('0, ST_EMPTY, 1'b1);
          end else begin
            queue_beat(ring[wrap(int'(head) + int'(fill) - 1)], ST_OK, 1'b1);
            fill--;
          end
        end
        REQ_LIST: begin
          if (fill == '0) begin
            queue_beat('0, ST_EMPTY, 1'b1);
          end else begin
            for (k = 0; k < int'(fill); k++) begin
              queue_beat(ring[wrap(int'(head) + k)], ST_OK, k == int'(fill) - 1);
            end
          end
        end
        default: begin
          // Spare codes leave the queue alone and produce no beat.
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Compare one result beat with the oldest predicted beat.
    task check_beat(logic signed [DATA_W-1:0] v, logic [1:0] st, logic lst);
      deque_beat_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat value %0d status %0d last %0d", v, st, lst));
        return;
      end
      want = awaited.pop_front();
      if (v !== want.value) begin
        report($sformatf("value %0d, predicted %0d", v, want.value));
      end
      if (st !== want.status) begin
        report($sformatf("status %0d, predicted %0d", st, want.status));
      end
      if (lst !== want.last) begin
        report($sformatf("last %0d, predicted %0d", lst, want.last));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               req_type = 3'd0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               status;
  logic                     last;

  // When set, neither side inserts gaps.
  bit calm = 1'b0;

  deque_scoreboard_t sb;

  double_ended_queue_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length in cycles: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mix of request codes, biased by the phase toward growing or shrinking the queue.
  function automatic logic [2:0] pick_request(phase_t phase);
    int r;
    int push_pct;
    r = $urandom_range(0, 99);
    case (phase)
      PHASE_FILL:  push_pct = 70;
      PHASE_DRAIN: push_pct = 15;
      default:     push_pct = 45;
    endcase
    if (r < 3) return 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    if (r < 13) return REQ_LIST;
    if (r < 13 + push_pct) return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
    return $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] corners [4];
    corners[0] = {1'b1, {(DATA_W-1){1'b0}}};
    corners[1] = {1'b0, {(DATA_W-1){1'b1}}};
    corners[2] = '0;
    corners[3] = '1;
    if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Drive one request beat and hold it until the block takes it.
  task automatic send_request(input logic [2:0] kind, input logic signed [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    item_value <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_request(kind, data);
  endtask

  // Result receiver: bursts of ready broken by stalls.
  initial begin : result_ready
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Every accepted result beat goes to the checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_beat(value, status, last);
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[double_ended_queue_core] ERROR");
    $finish;
  end

  // Reset, directed requests, random phases, then drain and verdict.
  initial begin : stimulus
    int counted;
    int len;
    phase_t phase;
    logic [2:0] kind;
    logic [2:0] spare;

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: listing and both pops report empty.
    send_request(REQ_LIST, pick_value());
    send_request(REQ_POP_FRONT, pick_value());
    send_request(REQ_POP_REAR, pick_value());
    // Rear pop of a single entry empties the queue.
    send_request(REQ_PUSH_REAR, {1'b0, {(DATA_W-1){1'b1}}});
    send_request(REQ_POP_REAR, pick_value());
    // Front push from position zero wraps the ring.
    send_request(REQ_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_request(REQ_PUSH_REAR, '1);
    send_request(REQ_PUSH_FRONT, '0);
    send_request(REQ_LIST, pick_value());
    for (spare = REQ_SPARE_FIRST; spare <= REQ_SPARE_LAST && spare != 3'd0; spare++) begin
      send_request(spare, pick_value());
    end
    send_request(REQ_POP_FRONT, pick_value());
    send_request(REQ_POP_REAR, pick_value());
    send_request(REQ_LIST, pick_value());
    send_request(REQ_POP_FRONT, pick_value());
    send_request(REQ_POP_FRONT, pick_value());

    // Random phases that fill, drain or churn the queue.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = phase_t'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      len = $urandom_range(8, 40);
      repeat (len) begin
        kind = pick_request(phase);
        send_request(kind, pick_value());
        if (kind <= REQ_LIST) counted++;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[double_ended_queue_core] OK");
    end else begin
      $display("[double_ended_queue_core] ERROR");
    end
    $finish;
  end

endmodule
